// ===== rtl/sinj_pkg.sv =====
`timescale 1ns / 1ps
package sinj_pkg;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] left_result;
    logic signed [15:0] right_result;
  } out_beat_t;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_AMP  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP = 4'd1;

  localparam logic [11:0] AMP_RESET  = 12'd100;
  localparam logic [31:0] STEP_RESET = 32'd178956971;

  // Noise generator
  localparam logic [31:0] LFSR_TAPS  = 32'hD000_0001;
  localparam logic [31:0] LFSR_RESET = 32'h0000_0001;

  // Quarter-wave polynomial coefficients, Q15
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [15:0] SIN_B = 16'd21167;
  localparam logic [15:0] SIN_C = 16'd2611;

  // 0.05 in Q16; the tone gain of 0.1 is twice this
  localparam logic signed [12:0] MIX_GAIN = 13'sd3277;

  // Digit-serial multiplier geometry
  localparam int MUL_W      = 16;
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = MUL_W / DIGIT_W;
  localparam int MUL_CNT_W  = 3;

  // Bit-serial remainder unit geometry
  localparam int DVD_W     = 15;
  localparam int DVS_W     = 12;
  localparam int MOD_CNT_W = 4;

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    lfsr_next = {1'b0, s[31:1]} ^ (s[0] ? LFSR_TAPS : 32'h0000_0000);
  endfunction

endpackage

// ===== rtl/sinj_mul.sv =====
`timescale 1ns / 1ps
module sinj_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sinj_pkg::MUL_W-1:0]    a,
  input  logic [sinj_pkg::MUL_W-1:0]    b,
  output logic [2*sinj_pkg::MUL_W-1:0]  prod,
  output logic                          done
);
  import sinj_pkg::*;

  logic [MUL_W-1:0]     a_r;
  logic [MUL_W-1:0]     b_r;
  logic [2*MUL_W-1:0]   prod_r;
  logic [2*MUL_W-1:0]   prod_nxt;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic                 done_r;

  // MSB digit first: shift the partial product up one digit, add a * digit
  assign prod_nxt = {prod_r[2*MUL_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
                  + (2*MUL_W)'(a_r) * (2*MUL_W)'(b_r[MUL_W-1 -: DIGIT_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= MUL_CNT_W'(MUL_DIGITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MUL_CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      prod_r <= '0;
    end else if (cnt_r != '0) begin
      b_r    <= {b_r[MUL_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;
  assign done = done_r;

endmodule

// ===== rtl/sinj_mod.sv =====
`timescale 1ns / 1ps
module sinj_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sinj_pkg::DVD_W-1:0]  dividend,
  input  logic [sinj_pkg::DVS_W-1:0]  divisor,
  output logic [sinj_pkg::DVS_W-1:0]  rem,
  output logic                        busy
);
  import sinj_pkg::*;

  logic [DVD_W-1:0]     dvd_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     rem_nxt;
  logic [DVS_W:0]       trial;
  logic [MOD_CNT_W-1:0] cnt_r;

  // Restoring step: bring down one dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= MOD_CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rem  = rem_r;
  assign busy = (cnt_r != '0);

endmodule

// ===== rtl/stereo_sine_and_random_noise_injector.sv =====
`timescale 1ns / 1ps
// Adds a sine tone and uniform pseudo-random noise to a stereo PCM stream.
// Input channel: in_valid / in_stall / in_data, one left/right pair per beat.
// Result channel: out_valid / out_stall / out_data, one pair per input beat,
// in order. Tone and noise peak at noise_amplitude; the sums saturate to 16 bits.
// Config channel: cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is
// always high. Index 0 is noise_amplitude (12 bits), index 1 is phase_step;
// other indexes are dropped. Write config only while the block is idle.
// One pair is worked at a time: a beat is accepted, its result is loaded into
// the output register after the products, the noise join and the scale step,
// and the next beat is taken the cycle after. The time is set by the sine
// polynomial and tone scaling, five products in a row on one 4-bit-digit
// multiplier; the two noise remainders run bit-serially in parallel with them.
// A held result in the output register does not block the next beat; only the
// final load waits for the register to free up under out_stall.
// Reset: amplitude 100, phase step 178956971, phase 0, noise register 1,
// output register empty.
module stereo_sine_and_random_noise_injector #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sinj_pkg::in_beat_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sinj_pkg::out_beat_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sinj_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [31:0]                        cfg_data
);
  import sinj_pkg::*;

  localparam int QW = SINE_INDEX_BITS - 2;
  localparam logic [QW:0] QSIZE = {1'b1, {QW{1'b0}}};

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_JOIN  = 3'd3;
  localparam logic [2:0] S_SCALE = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;

  // product sequence on the shared multiplier
  localparam logic [2:0] MS_XX  = 3'd0;
  localparam logic [2:0] MS_CX2 = 3'd1;
  localparam logic [2:0] MS_TX2 = 3'd2;
  localparam logic [2:0] MS_TX  = 3'd3;
  localparam logic [2:0] MS_AMP = 3'd4;

  logic [2:0]            state_r;
  logic [2:0]            step_r;
  logic [11:0]           amp_r;
  logic [31:0]           pstep_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic [31:0]           lfsr_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  in_beat_t              smp_r;
  logic [15:0]           x_r;
  logic                  neg_r;
  logic [15:0]           x2_r;
  logic [15:0]           t_r;
  logic [11:0]           tmag_r;
  logic signed [14:0]    wl_r;
  logic signed [14:0]    wr_r;
  logic signed [26:0]    suml_r;
  logic signed [26:0]    sumr_r;

  logic                  in_acc;
  logic                  out_free;
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [QW:0]           pos_e;
  logic [15:0]           x_nxt;
  logic [31:0]           lfsr_l;
  logic [31:0]           lfsr_rt;

  logic                  mul_start;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [2*MUL_W-1:0]    mul_prod;
  logic                  mul_done;
  logic [16:0]           s_raw;

  logic [DVS_W-1:0]      rem_l;
  logic [DVS_W-1:0]      rem_rt;
  logic                  busy_l;
  logic                  busy_rt;

  logic [11:0]           m_l;
  logic [11:0]           m_rt;
  logic signed [12:0]    tone;
  logic signed [13:0]    n_l;
  logic signed [13:0]    n_rt;
  logic signed [14:0]    wl_nxt;
  logic signed [14:0]    wr_nxt;
  logic signed [26:0]    wl_ext;
  logic signed [26:0]    wr_ext;

  function automatic logic signed [15:0] mix_sat(input logic signed [15:0] smp,
                                                 input logic signed [26:0] sum);
    logic signed [32:0] acc;
    logic signed [16:0] y;
    acc = $signed({smp[15], smp, 16'h0000}) + 33'(sum);
    // truncate toward zero
    if (acc[32]) begin
      acc = acc + 33'sd65535;
    end
    y = acc[32:16];
    if (y > 17'sd32767) begin
      mix_sat = 16'sh7FFF;
    end else if (y < -17'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = y[15:0];
    end
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // quarter-wave position from the top phase bits
  always_comb begin
    idx = phase_r[PHASE_BITS-1 -: SINE_INDEX_BITS];
    if (idx[SINE_INDEX_BITS-1 -: 2] == 2'b01 || idx[SINE_INDEX_BITS-1 -: 2] == 2'b11) begin
      pos_e = QSIZE - {1'b0, idx[QW-1:0]};
    end else begin
      pos_e = {1'b0, idx[QW-1:0]};
    end
    x_nxt = 16'(pos_e) << (15 - QW);
  end

  assign lfsr_l  = lfsr_next(lfsr_r);
  assign lfsr_rt = lfsr_next(lfsr_l);

  always_comb begin
    unique case (step_r)
      MS_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      MS_CX2: begin
        mul_a = SIN_C;
        mul_b = x2_r;
      end
      MS_TX2: begin
        mul_a = t_r;
        mul_b = x2_r;
      end
      MS_TX: begin
        mul_a = t_r;
        mul_b = x_r;
      end
      MS_AMP: begin
        mul_a = 16'(amp_r);
        mul_b = t_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_r == S_ISSUE);
  assign s_raw     = mul_prod[31:15];

  sinj_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  sinj_mod u_mod_l (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (lfsr_l[DVD_W-1:0]),
    .divisor  (amp_r),
    .rem      (rem_l),
    .busy     (busy_l)
  );

  sinj_mod u_mod_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (lfsr_rt[DVD_W-1:0]),
    .divisor  (amp_r),
    .rem      (rem_rt),
    .busy     (busy_rt)
  );

  // 0.1*tone + 0.05*noise = 0.05*(2*tone + noise)
  always_comb begin
    m_l  = (amp_r == '0) ? '0 : rem_l;
    m_rt = (amp_r == '0) ? '0 : rem_rt;
    tone = $signed({1'b0, tmag_r});
    if (neg_r) begin
      tone = -tone;
    end
    n_l    = $signed({1'b0, m_l, 1'b0}) - $signed({2'b00, amp_r});
    n_rt   = $signed({1'b0, m_rt, 1'b0}) - $signed({2'b00, amp_r});
    wl_nxt = 15'(n_l) + (15'(tone) <<< 1);
    wr_nxt = 15'(n_rt) + (15'(tone) <<< 1);
    wl_ext = 27'(wl_r);
    wr_ext = 27'(wr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= MS_XX;
      amp_r       <= AMP_RESET;
      pstep_r     <= STEP_RESET;
      phase_r     <= '0;
      lfsr_r      <= LFSR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_AMP) begin
          amp_r <= cfg_data[11:0];
        end else if (cfg_index == CFG_STEP) begin
          pstep_r <= cfg_data;
        end
      end

      if (state_r == S_MIX && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            phase_r <= phase_r + PHASE_BITS'(pstep_r);
            lfsr_r  <= lfsr_rt;
            step_r  <= MS_XX;
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            if (step_r == MS_AMP) begin
              state_r <= S_JOIN;
            end else begin
              step_r  <= step_r + 1'b1;
              state_r <= S_ISSUE;
            end
          end
        end
        S_JOIN: begin
          if (!busy_l && !busy_rt) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_r <= S_MIX;
        end
        S_MIX: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= in_data;
      x_r   <= x_nxt;
      neg_r <= idx[SINE_INDEX_BITS-1];
    end
    if (state_r == S_WAIT && mul_done) begin
      unique case (step_r)
        MS_XX:  x2_r   <= mul_prod[30:15];
        MS_CX2: t_r    <= SIN_B - mul_prod[30:15];
        MS_TX2: t_r    <= SIN_A - mul_prod[30:15];
        MS_TX:  t_r    <= (s_raw > 17'd32767) ? 16'd32767 : s_raw[15:0];
        MS_AMP: tmag_r <= mul_prod[26:15];
        default: ;
      endcase
    end
    if (state_r == S_JOIN) begin
      wl_r <= wl_nxt;
      wr_r <= wr_nxt;
    end
    if (state_r == S_SCALE) begin
      suml_r <= wl_ext * 27'(MIX_GAIN);
      sumr_r <= wr_ext * 27'(MIX_GAIN);
    end
    if (state_r == S_MIX && out_free) begin
      out_data_r.left_result  <= mix_sat(smp_r.left_sample, suml_r);
      out_data_r.right_result <= mix_sat(smp_r.right_sample, sumr_r);
    end
  end

endmodule
